### hw/rtl/atatf_pkg.sv
// ----------------------------------------------------------------------------
// atatf_pkg: shared types and constants of the ATA PIO task file device
// Register offsets, command codes, status bits, transfer phases and the
// control structures that pass between the task file and the data path.
// ----------------------------------------------------------------------------
package atatf_pkg;

  localparam int DEF_STORED_SECTORS = 64;
  localparam int DWORDS_PER_SECTOR  = 128;
  localparam int IDENTIFY_WORDS     = 256;
  localparam int SEC_IDX_W          = $clog2(DWORDS_PER_SECTOR);
  localparam int LBA_W              = 28;
  localparam int CFG_W              = 29;

  // register offsets
  localparam logic [2:0] PORT_DATA  = 3'd0;
  localparam logic [2:0] PORT_FEAT  = 3'd1;
  localparam logic [2:0] PORT_COUNT = 3'd2;
  localparam logic [2:0] PORT_LBA0  = 3'd3;
  localparam logic [2:0] PORT_LBA1  = 3'd4;
  localparam logic [2:0] PORT_LBA2  = 3'd5;
  localparam logic [2:0] PORT_DRIVE = 3'd6;
  localparam logic [2:0] PORT_CMD   = 3'd7;

  // access kinds and widths
  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_READ   = 1'b1;
  localparam logic [1:0] WID_BYTE  = 2'd0;
  localparam logic [1:0] WID_WORD  = 2'd1;
  localparam logic [1:0] WID_DWORD = 2'd2;

  // commands
  localparam logic [7:0] CMD_READ_SECT  = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECT = 8'h30;
  localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;

  // status and error bits
  localparam logic [7:0] ST_RDY   = 8'h40;
  localparam logic [7:0] ST_DRQ   = 8'h08;
  localparam logic [7:0] ST_ERR   = 8'h01;
  localparam logic [7:0] ERR_ABRT = 8'h04;

  localparam logic [3:0]       DH_RESET       = 4'hE;
  localparam logic [CFG_W-1:0] REPORTED_RESET = 29'd64;
  localparam logic [7:0]       ID_WORD_CAP_LO = 8'd60;
  localparam logic [7:0]       ID_WORD_CAP_HI = 8'd61;

  // transfer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_IDENT = 2'd3;

  localparam logic [7:0] SECT_LAST  = 8'(DWORDS_PER_SECTOR - 1);
  localparam logic [7:0] IDENT_LAST = 8'(IDENTIFY_WORDS - 1);

  typedef struct packed {
    logic                 opcode;
    logic [1:0]           access_width;
    logic [2:0]           port_offset;
    logic [31:0]          write_data;
  } in_item_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [LBA_W-1:0]     lba;
    logic [SEC_IDX_W-1:0] idx;
    logic [31:0]          wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 use_mem;
    logic [31:0]          imm;
    logic [1:0]           width;
  } rsp_t;

  function automatic logic [31:0] width_mask(input logic [1:0] w);
    logic [31:0] m;
    case (w)
      WID_BYTE: m = 32'h0000_00FF;
      WID_WORD: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/atatf_if.sv
// ----------------------------------------------------------------------------
// atatf_if: valid/ready channels of the ATA PIO task file device
// One channel carries bus accesses in, the other carries read data out.
// ----------------------------------------------------------------------------
interface atatf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  access_width;
  logic [2:0]  port_offset;
  logic [31:0] write_data;

  modport source (output valid, opcode, access_width, port_offset, write_data,
                  input ready);
  modport sink   (input valid, opcode, access_width, port_offset, write_data,
                  output ready);
endinterface

interface atatf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

### hw/rtl/atatf_taskfile.sv
// ----------------------------------------------------------------------------
// atatf_taskfile: task file registers and command decode
// Holds the LBA, drive, features, count, phase and error state, and turns
// bus accesses into sector memory requests and read responses.
// ----------------------------------------------------------------------------
module atatf_taskfile import atatf_pkg::*; #(
  parameter int STORED_SECTORS = DEF_STORED_SECTORS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_valid,
  input  in_item_t         acc,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output mem_req_t         req,
  output rsp_t             rsp
);

  localparam logic [LBA_W-1:0] LBA_LIMIT = LBA_W'(STORED_SECTORS);

  logic [LBA_W-1:0] lba_r, lba_nxt;
  logic [3:0]       dh_r, dh_nxt;
  logic [7:0]       feat_r, feat_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic             err_r, err_nxt;
  logic [CFG_W-1:0] rep_r;

  logic             lba_ok;
  logic [7:0]       b;
  logic             adv;
  logic [7:0]       adv_last;

  assign lba_ok = (lba_r < LBA_LIMIT);
  assign b      = acc.write_data[7:0];

  always_comb begin
    lba_nxt   = lba_r;
    dh_nxt    = dh_r;
    feat_nxt  = feat_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    adv       = 1'b0;
    adv_last  = SECT_LAST;
    req.rd    = 1'b0;
    req.wr    = 1'b0;
    req.lba   = lba_r;
    req.idx   = idx_r[SEC_IDX_W-1:0];
    req.wdata = acc.write_data & width_mask(acc.access_width);
    rsp.use_mem = 1'b0;
    rsp.imm     = 32'd0;
    rsp.width   = WID_DWORD;

    if (acc_valid) begin
      if (acc.opcode == OP_WRITE) begin
        case (acc.port_offset)
          PORT_DATA: begin
            if (phase_r == PH_WRITE) begin
              req.wr = lba_ok;
              adv    = 1'b1;
            end
          end
          PORT_FEAT:  feat_nxt  = b;
          PORT_COUNT: count_nxt = b;
          PORT_LBA0:  lba_nxt[7:0]   = b;
          PORT_LBA1:  lba_nxt[15:8]  = b;
          PORT_LBA2:  lba_nxt[23:16] = b;
          PORT_DRIVE: begin
            dh_nxt          = b[7:4];
            lba_nxt[27:24]  = b[3:0];
          end
          default: begin
            idx_nxt = 8'd0;
            if ((b inside {CMD_READ_SECT, CMD_WRITE_SECT}) && lba_ok) begin
              phase_nxt = (b == CMD_READ_SECT) ? PH_READ : PH_WRITE;
              err_nxt   = 1'b0;
            end else if (b == CMD_IDENTIFY) begin
              phase_nxt = PH_IDENT;
              err_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
              err_nxt   = 1'b1;
            end
          end
        endcase
      end else begin
        case (acc.port_offset)
          PORT_DATA: begin
            rsp.width = acc.access_width;
            if (phase_r == PH_READ) begin
              rsp.use_mem = lba_ok;
              req.rd      = lba_ok;
              adv         = 1'b1;
            end else if (phase_r == PH_IDENT) begin
              if (idx_r == ID_WORD_CAP_LO) begin
                rsp.imm = {16'd0, rep_r[15:0]};
              end else if (idx_r == ID_WORD_CAP_HI) begin
                rsp.imm = {19'd0, rep_r[CFG_W-1:16]};
              end
              adv      = 1'b1;
              adv_last = IDENT_LAST;
            end
          end
          PORT_FEAT:  rsp.imm = {24'd0, (err_r ? ERR_ABRT : 8'd0)};
          PORT_COUNT: rsp.imm = {24'd0, count_r};
          PORT_LBA0:  rsp.imm = {24'd0, lba_r[7:0]};
          PORT_LBA1:  rsp.imm = {24'd0, lba_r[15:8]};
          PORT_LBA2:  rsp.imm = {24'd0, lba_r[23:16]};
          PORT_DRIVE: rsp.imm = {24'd0, dh_r, lba_r[27:24]};
          default: begin
            rsp.imm = {24'd0, ST_RDY | ((phase_r != PH_IDLE) ? ST_DRQ : 8'd0)
                              | (err_r ? ST_ERR : 8'd0)};
          end
        endcase
      end
    end

    // step the transfer; close the phase after its last item
    if (adv) begin
      if (idx_r == adv_last) begin
        idx_nxt   = 8'd0;
        phase_nxt = PH_IDLE;
      end else begin
        idx_nxt = idx_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_r   <= '0;
      dh_r    <= DH_RESET;
      feat_r  <= 8'd0;
      count_r <= 8'd0;
      phase_r <= PH_IDLE;
      idx_r   <= 8'd0;
      err_r   <= 1'b0;
      rep_r   <= REPORTED_RESET;
    end else begin
      lba_r   <= lba_nxt;
      dh_r    <= dh_nxt;
      feat_r  <= feat_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      if (cfg_we) begin
        rep_r <= cfg_wdata;
      end
    end
  end

endmodule

### hw/rtl/ata_pio_task_file_device.sv
// ----------------------------------------------------------------------------
// ata_pio_task_file_device: drive side of an ATA PIO LBA28 task file
// A read transfer's result is held in the sector RAM read register and the
// response stage, then in the output register. Throughput: one bus access
// per cycle unless the response stage stalls; the single-port sector RAM
// serves one read or one write each cycle. Reset (synchronous, active low)
// clears the task file to idle, LBA 0, drive nibble 0xE; the sector RAM is
// not cleared and reads undefined until written.
// ----------------------------------------------------------------------------
module ata_pio_task_file_device import atatf_pkg::*; #(
  parameter int STORED_SECTORS = DEF_STORED_SECTORS
) (
  input  logic             clk,
  input  logic             rst_n,
  atatf_in_if.sink         in_bus,
  atatf_out_if.source      out_bus,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int MEM_DEPTH = STORED_SECTORS * DWORDS_PER_SECTOR;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  in_item_t  acc;
  logic      in_acc;
  mem_req_t  req;
  rsp_t      rsp;
  logic [MEM_AW-1:0] mem_addr;

  // sector store: one write or one registered read per cycle
  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] mem_q;

  // response stage (waits for the RAM read) and output register
  logic        s1_v_r, s1_v_nxt;
  rsp_t        s1_r, s1_nxt;
  logic        out_v_r, out_v_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        s1_go;

  assign acc.opcode       = in_bus.opcode;
  assign acc.access_width = in_bus.access_width;
  assign acc.port_offset  = in_bus.port_offset;
  assign acc.write_data   = in_bus.write_data;

  // the response stage drains whenever the output register is free or taken
  assign s1_go        = s1_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !s1_v_r || s1_go;
  assign in_acc       = in_bus.valid && in_bus.ready;

  atatf_taskfile #(
    .STORED_SECTORS (STORED_SECTORS)
  ) u_taskfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (in_acc),
    .acc       (acc),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // sector base times dwords per sector is a shift; the LBA is range-checked
  // upstream, so truncating to the RAM depth drops zero bits only
  assign mem_addr = MEM_AW'({req.lba, req.idx});

  // One access per cycle, so a write and a read never share an edge; a read
  // the cycle after a write to the same dword sees the new data. While the
  // response stage waits, no transfer is accepted, so mem_q holds.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[mem_addr] <= req.wdata;
    end
    if (req.rd) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_nxt       = s1_r;
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;

    // drop the output once taken; refill it from the response stage
    if (out_v_r && out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
    if (s1_go) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = (s1_r.use_mem ? mem_q : s1_r.imm) & width_mask(s1_r.width);
      s1_v_nxt     = 1'b0;
    end

    // only read transfers produce a result
    if (in_acc && (in_bus.opcode == OP_READ)) begin
      s1_v_nxt = 1'b1;
      s1_nxt   = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.read_data = out_data_r;

endmodule

### hw/rtl/atatf_checker.sv
// ----------------------------------------------------------------------------
// atatf_checker: port-level assertions of the task file device
// Tracks outstanding read transfers and checks result stability, count and timing.
// ----------------------------------------------------------------------------
module atatf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_read,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_rd_acc;
  logic       out_acc;

  assign in_rd_acc = in_valid && in_ready && in_read;
  assign out_acc   = out_valid && out_ready;
  assign pend_nxt  = pend_r + 2'(in_rd_acc) - 2'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two reads in flight, or a result without a read");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered with no read outstanding");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_rd_acc && pend_r == 2'd0 |-> ##2 out_valid)
    else $error("read on an empty pipe not answered in two cycles");

endmodule

bind ata_pio_task_file_device atatf_checker u_atatf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_read   (in_bus.opcode),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.read_data)
);
